### rtl/core/sdta_pkg.sv
`timescale 1ns / 1ps

package sdta_pkg;

    // width of the signed input word
    localparam int VALUE_WIDTH = 32;

    // decimal digits needed for magnitudes up to 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic dec_idx;
        logic emit_sign;
        logic emit_digit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic conv_last;
        logic dig_zero;
        logic idx_zero;
        logic neg;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/sdta_datapath.sv
`timescale 1ns / 1ps

module sdta_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [sdta_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic                                   i_stall,
    input  sdta_pkg::t_ctrl_cmd                    i_cmd,
    output sdta_pkg::t_dp_status                   o_status,
    output logic                                   o_valid,
    output logic [7:0]                             o_char_code,
    output logic                                   o_is_last
);

    localparam int W  = sdta_pkg::VALUE_WIDTH;
    localparam int NB = sdta_pkg::BCD_W;

    logic [W-1:0]                 r_mag, n_mag;
    logic [NB-1:0]                r_bcd, n_bcd;
    logic                         r_neg, n_neg;
    logic [sdta_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [sdta_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_char, n_char;
    logic                         r_last, n_last;

    logic [W-1:0]  in_bits;
    logic [NB-1:0] bcd_adj;
    logic [3:0]    cur_digit;
    logic          out_free;

    assign in_bits   = i_value;
    assign cur_digit = r_bcd[r_idx*4 +: 4];
    assign out_free  = !r_out_valid || !i_stall;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int d = 0; d < sdta_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        if (i_cmd.load) begin
            n_neg = in_bits[W-1];
            n_mag = in_bits[W-1] ? ((~in_bits) + W'(1)) : in_bits;
            n_bcd = '0;
            n_cnt = sdta_pkg::CNT_W'(W - 1);
            n_idx = sdta_pkg::IDX_W'(sdta_pkg::NUM_DIGITS - 1);
        end
        if (i_cmd.shift) begin
            n_bcd = {bcd_adj[NB-2:0], r_mag[W-1]};
            n_mag = {r_mag[W-2:0], 1'b0};
            n_cnt = r_cnt - sdta_pkg::CNT_W'(1);
        end
        if (i_cmd.dec_idx) begin
            n_idx = r_idx - sdta_pkg::IDX_W'(1);
        end

        if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit_sign) begin
            n_out_valid = 1'b1;
            n_char      = sdta_pkg::CH_MINUS;
            n_last      = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_out_valid = 1'b1;
            n_char      = sdta_pkg::CH_ZERO + {4'd0, cur_digit};
            n_last      = (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_status.conv_last = (r_cnt == '0);
    assign o_status.dig_zero  = (cur_digit == 4'd0);
    assign o_status.idx_zero  = (r_idx == '0);
    assign o_status.neg       = r_neg;
    assign o_status.out_free  = out_free;

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

### rtl/core/sdta_ctrl.sv
`timescale 1ns / 1ps

module sdta_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sdta_pkg::t_dp_status i_status,
    output sdta_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_busy
);

    sdta_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdta_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdta_pkg::ST_IDLE: begin
                if (i_valid) n_state = sdta_pkg::ST_CONV;
            end
            sdta_pkg::ST_CONV: begin
                if (i_status.conv_last) n_state = sdta_pkg::ST_SKIP;
            end
            sdta_pkg::ST_SKIP: begin
                if (!i_status.dig_zero || i_status.idx_zero) begin
                    n_state = i_status.neg ? sdta_pkg::ST_SIGN : sdta_pkg::ST_DIGIT;
                end
            end
            sdta_pkg::ST_SIGN: begin
                if (i_status.out_free) n_state = sdta_pkg::ST_DIGIT;
            end
            sdta_pkg::ST_DIGIT: begin
                if (i_status.out_free && i_status.idx_zero) n_state = sdta_pkg::ST_IDLE;
            end
            default: begin
                n_state = sdta_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            sdta_pkg::ST_IDLE: begin
                o_cmd.load = i_valid;
            end
            sdta_pkg::ST_CONV: begin
                o_cmd.shift = 1'b1;
            end
            sdta_pkg::ST_SKIP: begin
                o_cmd.dec_idx = i_status.dig_zero && !i_status.idx_zero;
            end
            sdta_pkg::ST_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            sdta_pkg::ST_DIGIT: begin
                o_cmd.emit_digit = i_status.out_free;
                o_cmd.dec_idx    = i_status.out_free && !i_status.idx_zero;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != sdta_pkg::ST_IDLE);

endmodule

### rtl/core/signed_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Converts one signed two's complement word per input transaction into its
// decimal text, one ASCII character per output transaction: '-' first for a
// negative value, then the digits most significant first without leading
// zeros; zero gives the single character '0'. o_is_last marks the final
// character of each run. The full range is converted exactly, the most
// negative value included. Order of work: the accept cycle, then one
// double-dabble step per input bit, then a scan down the ten digit
// positions that passes over leading zero digits, then one character per
// cycle while the output is not stalled. o_stall stays high from accept
// until the last character has been loaded into the output register;
// that character may still be waiting on the output while the next
// number is taken.

module signed_to_decimal_ascii (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [sdta_pkg::VALUE_WIDTH-1:0] i_value,
    // output channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [7:0]                             o_char_code,
    output logic                                   o_is_last
);

    sdta_pkg::t_ctrl_cmd  cmd;
    sdta_pkg::t_dp_status status;
    logic                 busy;

    sdta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sdta_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    // busy from accept until the last character is handed to the output register
    assign o_stall = busy;

    // an accepted number keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not closed after accepting a number");

    // a character is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // a sign only goes out for negative numbers
    a_sign_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_sign |-> status.neg)
        else $error("minus emitted for non-negative value");

    // the minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == sdta_pkg::CH_MINUS) |-> !o_is_last)
        else $error("run ends on a minus sign");

endmodule

### bench/signed_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

// Bench for signed_to_decimal_ascii.
// A directed set hits the edges of the range, then four random phases vary
// the idling on both channels, then one burst waits for the output to drain
// before it goes on. Every character that leaves the block is checked
// against a queue filled by a local predictor at input acceptance.

module signed_to_decimal_ascii_test;

    localparam int CLK_HALF   = 4;           // 8 ns period
    localparam int RADIX      = 10;
    localparam int TAIL_WAIT  = 64;          // idle tail after the output has drained
    localparam int CYCLE_CAP  = 400_000;     // far beyond the slowest legal run
    localparam int MAX_REPORT = 10;

    // one predicted output transaction
    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic                                    i_clk   = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_valid = 1'b0;
    logic signed [sdta_pkg::VALUE_WIDTH-1:0] i_value = '0;
    logic                                    i_stall = 1'b0;
    logic                                    o_stall;
    logic                                    o_valid;
    logic [7:0]                              o_char_code;
    logic                                    o_is_last;

    t_char pending_chars [$];   // characters still owed by the block
    int    mismatches    = 0;
    int    cycle_count   = 0;
    int    send_idle_pct = 0;   // chance per cycle that the sender holds off
    int    recv_stall_pct = 0;  // chance per cycle that the receiver stalls

    signed_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Predictor: the decimal text of one word, appended to pending_chars.
    // The magnitude is formed unsigned, so the most negative word comes
    // out exactly.
    function automatic void predict_decimal_text(
        input logic [sdta_pkg::VALUE_WIDTH-1:0] word
    );
        logic [sdta_pkg::VALUE_WIDTH-1:0] mag;
        logic [7:0]                       digits [$];
        logic                             negative;
        t_char                            c;
        negative = word[sdta_pkg::VALUE_WIDTH-1];
        mag      = negative ? (~word + 1'b1) : word;
        if (mag == 0) begin
            c.code = sdta_pkg::CH_ZERO;
            c.last = 1'b1;
            pending_chars.push_back(c);
            return;
        end
        while (mag != 0) begin
            digits.push_front(sdta_pkg::CH_ZERO + 8'(mag % RADIX));
            mag = mag / RADIX;
        end
        if (negative) begin
            c.code = sdta_pkg::CH_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        foreach (digits[i]) begin
            c.code = digits[i];
            c.last = (i == digits.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORT) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
    endfunction

    // Stimulus mix: full-range words, short numbers, powers of ten and
    // their neighbours (digit count changes), and words near both limits.
    function automatic logic [sdta_pkg::VALUE_WIDTH-1:0] random_word();
        logic [sdta_pkg::VALUE_WIDTH-1:0] w;
        logic [sdta_pkg::VALUE_WIDTH-1:0] p;
        int                               k;
        p = 1;
        case ($urandom_range(3))
            0: begin
                w = $urandom;
            end
            1: begin
                w = $urandom_range(0, 999);
                if ($urandom_range(1)) w = -w;
            end
            2: begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * RADIX;
                w = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(1)) w = -w;
            end
            default: begin
                if ($urandom_range(1)) w = 32'h7FFF_FFFF - $urandom_range(0, 15);
                else                   w = 32'h8000_0000 + $urandom_range(0, 15);
            end
        endcase
        return w;
    endfunction

    // Offers one word and returns once it has been accepted. Valid is left
    // high afterwards; the next call decides whether it drops for a gap.
    task automatic send_word(input logic [sdta_pkg::VALUE_WIDTH-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_decimal_text(word);
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Edges of the range, every digit value, run lengths 1 to 4 and 9 to 11.
    task automatic test_directed();
        send_word(0);
        send_word(1);
        send_word(-1);
        send_word(9);
        send_word(10);
        send_word(-10);
        send_word(99);
        send_word(100);
        send_word(-101);
        send_word(1234567890);
        send_word(-987654321);
        send_word(999_999_999);
        send_word(1_000_000_000);
        send_word(-1_000_000_000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h8000_0001);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        send_word(-5);
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_word(random_word());
    endtask

    // Sender holds back until every owed character has been seen.
    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        repeat (5) send_word(random_word());
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        repeat (5) send_word(random_word());
    endtask

    // Output side: check each accepted transaction, then pick the next stall.
    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected char %0d last %0b",
                                        o_char_code, o_is_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code || o_is_last !== want.last) begin
                    note_mismatch($sformatf("char exp %0d/%0b got %0d/%0b",
                                            want.code, want.last,
                                            o_char_code, o_is_last));
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(110, 0, 0);
        test_random_phase(110, 87, 0);
        test_random_phase(110, 0, 87);
        test_random_phase(110, 20, 20);
        test_pause_until_drained();

        i_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sdta_pkg.sv
rtl/core/sdta_datapath.sv
rtl/core/sdta_ctrl.sv
rtl/core/signed_to_decimal_ascii.sv
bench/signed_to_decimal_ascii_test.sv
